// ===== design/mcs_pkg.sv =====
// Shared types and constants for the majority consensus select block.
package mcs_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned WIN_IDX_W = 6;
  localparam int unsigned AGREE_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [VAL_W-1:0]   MAX_DIFF_RST  = 16'd7680;
  localparam logic [AGREE_W-1:0] MIN_AGREE_RST = 9'd166;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AGREE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ACC,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr;
    logic init;
    logic acc;
    logic scan;
  } cell_ctrl_t;

endpackage

// ===== design/mcs_cell.sv =====
// One cell of the row: holds one value, compares it to the values passing by.
module mcs_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned SUM_W = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mcs_pkg::cell_ctrl_t          ctrl_i,
  input  logic [IDX_W-1:0]             wr_idx_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [mcs_pkg::VAL_W-1:0]    sample_i,
  input  logic [mcs_pkg::VAL_W-1:0]    max_diff_i,
  input  logic [mcs_pkg::VAL_W-1:0]    m_i,
  input  logic                         mv_i,
  input  logic [CNT_W-1:0]             agree_i,
  input  logic [SUM_W-1:0]             sum_i,
  output logic [mcs_pkg::VAL_W-1:0]    m_o,
  output logic                         mv_o,
  output logic [CNT_W-1:0]             agree_o,
  output logic [SUM_W-1:0]             sum_o
);

  logic [mcs_pkg::VAL_W-1:0] v_q;
  logic [mcs_pkg::VAL_W-1:0] m_q;
  logic                      mv_q;
  logic [CNT_W-1:0]          agree_q;
  logic [SUM_W-1:0]          sum_q;
  logic [mcs_pkg::VAL_W-1:0] diff;

  assign diff = (v_q > m_q) ? (v_q - m_q) : (m_q - v_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && (wr_idx_i == IDX_W'(IDX))) begin
      v_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      m_q <= v_q;
    end else if (ctrl_i.acc) begin
      m_q <= m_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q    <= 1'b0;
      agree_q <= '0;
      sum_q   <= '0;
    end else if (ctrl_i.init) begin
      mv_q    <= (CNT_W'(IDX) < count_i);
      agree_q <= '0;
      sum_q   <= '0;
    end else if (ctrl_i.acc) begin
      mv_q <= mv_i;
      if (mv_q) begin
        agree_q <= agree_q + CNT_W'(diff < max_diff_i);
        sum_q   <= sum_q + SUM_W'(diff);
      end
    end else if (ctrl_i.scan) begin
      agree_q <= agree_i;
      sum_q   <= sum_i;
    end
  end

  assign m_o     = m_q;
  assign mv_o    = mv_q;
  assign agree_o = agree_q;
  assign sum_o   = sum_q;

endmodule

// ===== design/majority_consensus_select.sv =====
// Top level of the majority consensus select block: control, cell row, selection.
//
// Usage: drive sample_value_i and is_last_i with start_i high; a request is
// taken at a rising edge where start_i is high and busy_o is low. Values are
// stored in load order in a row of MAX_VALUES cells, one per cycle; values
// beyond capacity are dropped and reported through overflowed_o.
// A request with is_last_i high closes the set. The block then goes busy:
// it copies the stored values into a ring, rotates the ring so that every
// cell accumulates its agreement count and distance sum, then shifts the
// per-cell results, one per stored value, to the selector, which checks one
// candidate per cycle. The result is on the result ports for one cycle with
// valid_o high, and busy_o drops in the following cycle.
// Non-closing requests give no result and leave the block idle.
// The receiver cannot stall; the result is presented exactly once.
// Configuration writes on cfg_valid_i/cfg_ready_o are always taken and must
// happen only while the block is idle. Reset clears the set, the selection
// state and loads max_diff = 7680 and min_agree = 166; no clearing pass runs.
module majority_consensus_select #(
  parameter int unsigned MAX_VALUES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [mcs_pkg::VAL_W-1:0]           sample_value_i,
  input  logic                                is_last_i,
  output logic                                valid_o,
  output logic                                found_o,
  output logic [mcs_pkg::WIN_IDX_W-1:0]       winner_index_o,
  output logic                                overflowed_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_VALUES + 1);
  localparam int unsigned SUM_W = mcs_pkg::VAL_W + IDX_W;
  localparam int unsigned TH_W  = mcs_pkg::AGREE_W + CNT_W;

  mcs_pkg::state_e state_q, state_d;
  mcs_pkg::cell_ctrl_t ctrl;

  logic [mcs_pkg::VAL_W-1:0]   max_diff_q;
  logic [mcs_pkg::AGREE_W-1:0] min_agree_q;
  logic [CNT_W-1:0]            count_q;
  logic                        dropped_q;
  logic [CNT_W-1:0]            step_q;
  logic [TH_W-1:0]             thresh_q;
  logic [CNT_W-1:0]            best_agree_q;
  logic [SUM_W-1:0]            best_sum_q;
  logic [IDX_W-1:0]            best_pos_q;
  logic                        have_best_q;
  logic                        room;
  logic                        accept;
  logic                        acc_end;
  logic                        scan_end;
  logic                        take;

  logic [mcs_pkg::VAL_W-1:0] m_w     [MAX_VALUES];
  logic                      mv_w    [MAX_VALUES];
  logic [CNT_W-1:0]          agree_w [MAX_VALUES];
  logic [SUM_W-1:0]          sum_w   [MAX_VALUES];

  assign room     = (count_q < CNT_W'(MAX_VALUES));
  assign accept   = start_i && (state_q == mcs_pkg::ST_IDLE);
  assign acc_end  = (step_q == CNT_W'(MAX_VALUES - 1));
  assign scan_end = (step_q == (count_q - CNT_W'(1)));
  assign take     = (sum_w[0] < best_sum_q) && (agree_w[0] >= best_agree_q) &&
                    ({TH_W'(agree_w[0]), 8'b0} >= {8'b0, thresh_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      mcs_pkg::ST_IDLE: if (accept && is_last_i) state_d = mcs_pkg::ST_INIT;
      mcs_pkg::ST_INIT: state_d = mcs_pkg::ST_ACC;
      mcs_pkg::ST_ACC:  if (acc_end) state_d = mcs_pkg::ST_SCAN;
      mcs_pkg::ST_SCAN: if (scan_end) state_d = mcs_pkg::ST_DONE;
      mcs_pkg::ST_DONE: state_d = mcs_pkg::ST_IDLE;
      default:          state_d = mcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl    = '0;
    busy_o  = 1'b1;
    valid_o = 1'b0;
    case (state_q)
      mcs_pkg::ST_IDLE: begin
        busy_o  = 1'b0;
        ctrl.wr = accept && room;
      end
      mcs_pkg::ST_INIT: ctrl.init = 1'b1;
      mcs_pkg::ST_ACC:  ctrl.acc = 1'b1;
      mcs_pkg::ST_SCAN: ctrl.scan = 1'b1;
      mcs_pkg::ST_DONE: valid_o = 1'b1;
      default:          busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q  <= mcs_pkg::MAX_DIFF_RST;
      min_agree_q <= mcs_pkg::MIN_AGREE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mcs_pkg::REG_MAX_DIFF:  max_diff_q <= cfg_data_i;
        mcs_pkg::REG_MIN_AGREE: min_agree_q <= cfg_data_i[mcs_pkg::AGREE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      step_q       <= '0;
      thresh_q     <= '0;
      best_agree_q <= '0;
      best_sum_q   <= '1;
      best_pos_q   <= '0;
      have_best_q  <= 1'b0;
    end else begin
      case (state_q)
        mcs_pkg::ST_IDLE: begin
          if (accept) begin
            if (room) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        mcs_pkg::ST_INIT: begin
          step_q   <= '0;
          thresh_q <= TH_W'(min_agree_q) * TH_W'(count_q);
        end
        mcs_pkg::ST_ACC: begin
          step_q <= acc_end ? '0 : step_q + CNT_W'(1);
        end
        mcs_pkg::ST_SCAN: begin
          step_q <= step_q + CNT_W'(1);
          if (take) begin
            best_agree_q <= agree_w[0];
            best_sum_q   <= sum_w[0];
            best_pos_q   <= step_q[IDX_W-1:0];
            have_best_q  <= 1'b1;
          end
        end
        mcs_pkg::ST_DONE: begin
          count_q      <= '0;
          dropped_q    <= 1'b0;
          best_agree_q <= '0;
          best_sum_q   <= '1;
          best_pos_q   <= '0;
          have_best_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign found_o        = have_best_q;
  assign winner_index_o = have_best_q ? mcs_pkg::WIN_IDX_W'(best_pos_q) : '0;
  assign overflowed_o   = dropped_q;

  for (genvar k = 0; k < MAX_VALUES; k++) begin : g_cell
    localparam int unsigned NXT = (k + 1) % MAX_VALUES;
    logic [CNT_W-1:0] agree_in;
    logic [SUM_W-1:0] sum_in;

    if (k == MAX_VALUES - 1) begin : g_tail
      assign agree_in = '0;
      assign sum_in   = '0;
    end else begin : g_body
      assign agree_in = agree_w[NXT];
      assign sum_in   = sum_w[NXT];
    end

    mcs_cell #(
      .IDX   (k),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_idx_i   (count_q[IDX_W-1:0]),
      .count_i    (count_q),
      .sample_i   (sample_value_i),
      .max_diff_i (max_diff_q),
      .m_i        (m_w[NXT]),
      .mv_i       (mv_w[NXT]),
      .agree_i    (agree_in),
      .sum_i      (sum_in),
      .m_o        (m_w[k]),
      .mv_o       (mv_w[k]),
      .agree_o    (agree_w[k]),
      .sum_o      (sum_w[k])
    );
  end

  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  a_valid_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == mcs_pkg::ST_SCAN)
    else $error("result without a completed scan");

  a_no_winner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (winner_index_o == '0))
    else $error("winner index nonzero without a winner");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VALUES))
    else $error("set count beyond capacity");

  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && is_last_i) |=> busy_o)
    else $error("closing request did not start selection");

endmodule
